// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants and types of the rejection sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;
    localparam int MAX_POPULATION = 1024;
    localparam int MAX_SAMPLE     = 16;
    localparam int WEIGHT_BITS    = 32;
    localparam int IDX_W          = $clog2(MAX_POPULATION);
    localparam int POS_W          = $clog2(MAX_SAMPLE);
    localparam int CNT_W          = POS_W + 1;
    localparam int PSZ_W          = 11;
    localparam int SSZ_W          = 5;
    localparam int TRY_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;

    localparam logic [1:0] OP_LOAD_W = 2'd0;
    localparam logic [1:0] OP_LOAD_R = 2'd1;
    localparam logic [1:0] OP_DRAW   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMP = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture the input beat
        logic write_tab;  // write a table entry
        logic rd_total;   // read the last entry
        logic set_target; // form target from the total
        logic probe_rd;   // read mid entry
        logic probe_upd;  // narrow search bounds
        logic dup_start;  // start duplicate scan
        logic dup_step;   // check one chosen member
        logic commit;     // store member
        logic reject;     // drop partial sample
        logic emit_start; // start output run
        logic emit_next;  // advance output run
        logic cfg_clear;  // configuration write
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic is_draw;
        logic search_done;
        logic dup_done;
        logic dup_hit;
        logic full;
        logic emit_last;
    } t_stat;
endpackage
`default_nettype wire

// ----- design/pps_stream_if.sv -----
// ----------------------------------------------------------------------------
// pps_in_if / pps_out_if
// Valid-ready channels of the sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface pps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [9:0]  entry_index;
    logic [31:0] entry_value;
    logic [31:0] random_fraction;
    modport source (output valid, opcode, entry_index, entry_value, random_fraction,
                    input ready);
    modport sink (input valid, opcode, entry_index, entry_value, random_fraction,
                  output ready);
endinterface

interface pps_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  member_index;
    logic [3:0]  position;
    logic        last;
    logic [15:0] try_count;
    modport source (output valid, member_index, position, last, try_count,
                    input ready);
    modport sink (input valid, member_index, position, last, try_count,
                  output ready);
endinterface
`default_nettype wire

// ----- design/pps_ctrl.sv -----
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for loads, table search, duplicate scan and output run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pps_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  wire             i_cfg_we,
    input  pps_pkg::t_stat  i_stat,
    output pps_pkg::t_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_TOTAL, S_TARGET, S_PROBE_RD, S_PROBE_UPD,
        S_DUP, S_COMMIT, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_out_valid = r_out_valid;

    // Next state and combinational commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.cfg_clear = i_cfg_we;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_load) begin
                    o_cmd.write_tab = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.is_draw) begin
                    o_cmd.rd_total = 1'b1;
                    n_state = S_TOTAL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TOTAL: n_state = S_TARGET;
            S_TARGET: begin
                o_cmd.set_target = 1'b1;
                n_state = S_PROBE_RD;
            end
            S_PROBE_RD: begin
                if (i_stat.search_done) begin
                    o_cmd.dup_start = 1'b1;
                    n_state = S_DUP;
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state = S_PROBE_UPD;
                end
            end
            S_PROBE_UPD: begin
                o_cmd.probe_upd = 1'b1;
                n_state = S_PROBE_RD;
            end
            S_DUP: begin
                if (i_stat.dup_hit) begin
                    o_cmd.reject = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.dup_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.dup_step = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_stat.full) begin
                    o_cmd.emit_start = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_stat.emit_last) begin
                        n_out_valid = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ----- design/pps_datapath.sv -----
// ----------------------------------------------------------------------------
// pps_datapath
// Tables, binary search, chosen-member store and output run counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pps_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  pps_pkg::t_cmd                    i_cmd,
    output pps_pkg::t_stat                   o_stat,
    input  wire [1:0]                        i_opcode,
    input  wire [pps_pkg::IDX_W-1:0]         i_entry_index,
    input  wire [31:0]                       i_entry_value,
    input  wire [31:0]                       i_random_fraction,
    input  wire [pps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [pps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [pps_pkg::IDX_W-1:0]        o_member_index,
    output logic [pps_pkg::POS_W-1:0]        o_position,
    output logic                             o_last,
    output logic [pps_pkg::TRY_W-1:0]        o_try_count
);
    localparam int IW = pps_pkg::IDX_W;
    localparam int WB = pps_pkg::WEIGHT_BITS;
    localparam int CW = pps_pkg::CNT_W;

    // Tables held in block memories.
    logic [WB-1:0] r_wtab [pps_pkg::MAX_POPULATION];
    logic [WB-1:0] r_rtab [pps_pkg::MAX_POPULATION];
    logic [WB-1:0] r_rd;

    logic [1:0]    r_op;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_val;
    logic [31:0]   r_u;
    logic          r_use_ratio;

    logic [pps_pkg::PSZ_W-1:0] r_psize;
    logic [pps_pkg::SSZ_W-1:0] r_ssize;
    logic [IW:0]   eff_p;
    logic [CW-1:0] eff_k;

    logic [WB-1:0] r_target;
    logic [IW:0]   r_lo, r_hi;
    logic [IW-1:0] mid;

    logic [IW-1:0] r_chosen [pps_pkg::MAX_SAMPLE];
    logic [CW-1:0] r_drawn;
    logic [CW-1:0] r_scan;
    logic          r_hit;
    logic [pps_pkg::TRY_W-1:0] r_tries;
    logic [CW-1:0] r_emit;

    logic [WB+31:0] prod;
    logic [IW-1:0]  rd_addr;

    // Effective sizes with clamping.
    always_comb begin
        if (r_psize == '0) eff_p = (IW+1)'(1);
        else if (r_psize > pps_pkg::PSZ_W'(pps_pkg::MAX_POPULATION))
            eff_p = (IW+1)'(pps_pkg::MAX_POPULATION);
        else eff_p = (IW+1)'(r_psize);
        if (r_ssize == '0) eff_k = CW'(1);
        else if (r_ssize > pps_pkg::SSZ_W'(pps_pkg::MAX_SAMPLE))
            eff_k = CW'(pps_pkg::MAX_SAMPLE);
        else eff_k = CW'(r_ssize);
    end

    assign mid     = IW'((r_lo + r_hi) >> 1);
    assign rd_addr = i_cmd.rd_total ? IW'(eff_p - 1'b1) : mid;
    assign prod    = r_rd * r_u;

    // Table write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_tab && r_op == pps_pkg::OP_LOAD_W) r_wtab[r_idx] <= r_val;
        if (i_cmd.write_tab && r_op == pps_pkg::OP_LOAD_R) r_rtab[r_idx] <= r_val;
        if (i_cmd.rd_total || i_cmd.probe_rd)
            r_rd <= r_use_ratio ? r_rtab[rd_addr] : r_wtab[rd_addr];
    end

    // Input capture, search bounds, duplicate scan, member store and output run counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_opcode;
            r_idx <= i_entry_index;
            r_val <= i_entry_value;
            r_u   <= i_random_fraction;
            r_use_ratio <= (r_drawn != '0);
        end
        if (i_cmd.set_target) begin
            r_target <= WB'(prod >> 32);
            r_lo <= '0;
            r_hi <= eff_p - 1'b1;
        end
        if (i_cmd.probe_upd) begin
            if (r_target <= r_rd) r_hi <= (IW+1)'(mid);
            else r_lo <= (IW+1)'(mid) + 1'b1;
        end
        if (i_cmd.dup_start) begin
            r_scan <= '0;
            r_hit  <= 1'b0;
        end
        if (i_cmd.dup_step) begin
            if (r_chosen[r_scan[CW-2:0]] == IW'(r_lo)) r_hit <= 1'b1;
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.commit) r_chosen[r_drawn[CW-2:0]] <= IW'(r_lo);
        if (i_cmd.emit_start) r_emit <= '0;
        if (i_cmd.emit_next) r_emit <= r_emit + 1'b1;
    end

    // Control counters and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psize <= pps_pkg::PSZ_W'(pps_pkg::MAX_POPULATION);
            r_ssize <= pps_pkg::SSZ_W'(1);
            r_drawn <= '0;
            r_tries <= pps_pkg::TRY_W'(1);
        end else if (i_cmd.cfg_clear) begin
            if (i_cfg_index == pps_pkg::CFG_POP) r_psize <= i_cfg_data;
            else r_ssize <= pps_pkg::SSZ_W'(i_cfg_data);
            r_drawn <= '0;
            r_tries <= pps_pkg::TRY_W'(1);
        end else if (i_cmd.reject) begin
            r_drawn <= '0;
            if (r_tries != '1) r_tries <= r_tries + 1'b1;
        end else if (i_cmd.commit) begin
            r_drawn <= r_drawn + 1'b1;
        end else if (i_cmd.emit_next && o_stat.emit_last) begin
            r_drawn <= '0;
            r_tries <= pps_pkg::TRY_W'(1);
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.is_load     = (r_op == pps_pkg::OP_LOAD_W) || (r_op == pps_pkg::OP_LOAD_R);
        o_stat.is_draw     = (r_op == pps_pkg::OP_DRAW);
        o_stat.search_done = (r_lo >= r_hi);
        o_stat.dup_hit     = r_hit;
        o_stat.dup_done    = (r_scan >= r_drawn);
        o_stat.full        = (r_drawn + 1'b1 >= eff_k);
        o_stat.emit_last   = (r_emit + 1'b1 >= r_drawn);
    end

    assign o_member_index = r_chosen[r_emit[CW-2:0]];
    assign o_position     = r_emit[CW-2:0];
    assign o_last         = o_stat.emit_last;
    assign o_try_count    = r_tries;
endmodule
`default_nettype wire

// ----- design/pps_rejection_sampler.sv -----
// Flow: a load decodes and then writes its table entry; a draw reads the total, forms a target,
// then runs a binary search over the table memory and a serial duplicate scan.
// Throughput: one item at a time; a full sample then emits K beats, one a cycle while out ready is high.
// Reset: synchronous active low; population 1024, sample size 1, tables undefined.
// ----------------------------------------------------------------------------
// pps_rejection_sampler
// Sampford PPS sampler without replacement, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pps_rejection_sampler (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    pps_in_if.sink                        in_ch,
    pps_out_if.source                     out_ch,
    input  wire                           i_cfg_we,
    input  wire [pps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [pps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    pps_pkg::t_cmd  cmd;
    pps_pkg::t_stat stat;

    pps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_cfg_we(i_cfg_we), .i_stat(stat), .o_cmd(cmd)
    );

    pps_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_opcode(in_ch.opcode), .i_entry_index(in_ch.entry_index),
        .i_entry_value(in_ch.entry_value), .i_random_fraction(in_ch.random_fraction),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_member_index(out_ch.member_index), .o_position(out_ch.position),
        .o_last(out_ch.last), .o_try_count(out_ch.try_count)
    );

    // No input is taken while a sample run is on the output.
    `ASSERT_IMPL(a_no_in_during_out, i_clk, i_rst_n, out_ch.valid, !in_ch.ready, "input ready during output run")
    // A rejection never coincides with a member store.
    `ASSERT_IMPL(a_rej_commit, i_clk, i_rst_n, cmd.reject, !cmd.commit, "reject and commit together")
    // After the last beat the output goes idle.
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, out_ch.valid && out_ch.ready && out_ch.last, !out_ch.valid, "output run continued after last")
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the PPS rejection sampler
// Loads cumulative weight and ratio tables, draws samples under several
// population and sample size settings, and checks every output beat
// against an in-bench prediction of the sampler, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [31:0] val;
        logic [31:0] frac;
    } t_item;

    typedef struct packed {
        logic [9:0]  member;
        logic [3:0]  pos;
        logic        last;
        logic [15:0] tries;
    } t_member_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pps_in_if  in_ch();
    pps_out_if out_ch();

    pps_rejection_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted sampler state.
    logic [31:0] weight_mem [pps_pkg::MAX_POPULATION];
    logic [31:0] ratio_mem [pps_pkg::MAX_POPULATION];
    logic [9:0]  picked [pps_pkg::MAX_SAMPLE];
    int unsigned picked_cnt = 0;
    logic [15:0] attempts = 16'd1;
    logic [pps_pkg::PSZ_W-1:0] pop_reg = 11'd1024;
    logic [pps_pkg::SSZ_W-1:0] samp_reg = 5'd1;

    // Values the stimulus has queued for the tables, to keep them nondecreasing.
    logic [31:0] plan_w [pps_pkg::MAX_POPULATION];
    logic [31:0] plan_r [pps_pkg::MAX_POPULATION];

    t_item        pending_items [$];
    t_member_beat sample_beats [$];
    int  errors = 0;
    bit  fast_feed = 1'b0;
    bit  all_done = 1'b0;

    function automatic int unsigned units_in_use();
        if (pop_reg == 0) return 1;
        if (pop_reg > pps_pkg::MAX_POPULATION) return pps_pkg::MAX_POPULATION;
        return pop_reg;
    endfunction

    function automatic int unsigned members_per_sample();
        if (samp_reg == 0) return 1;
        if (samp_reg > pps_pkg::MAX_SAMPLE) return pps_pkg::MAX_SAMPLE;
        return samp_reg;
    endfunction

    // First unit whose cumulative value reaches floor(total * u).
    function automatic logic [9:0] locate_unit(bit from_ratio, logic [31:0] u);
        int unsigned p;
        logic [31:0] total;
        logic [63:0] prod;
        logic [31:0] goal;
        p = units_in_use();
        total = from_ratio ? ratio_mem[p-1] : weight_mem[p-1];
        prod = {32'd0, total} * {32'd0, u};
        goal = prod[63:32];
        for (int unsigned i = 0; i < p; i++) begin
            if (goal <= (from_ratio ? ratio_mem[i] : weight_mem[i])) return i[9:0];
        end
        return p[9:0] - 10'd1;
    endfunction

    // Apply one accepted input beat and queue the members it completes.
    task automatic apply_item(t_item it);
        logic [9:0] unit;
        int unsigned k;
        k = members_per_sample();
        case (it.op)
            pps_pkg::OP_LOAD_W: weight_mem[it.idx] = it.val;
            pps_pkg::OP_LOAD_R: ratio_mem[it.idx] = it.val;
            pps_pkg::OP_DRAW: begin
                if (picked_cnt >= k) picked_cnt = 0;
                unit = locate_unit(picked_cnt != 0, it.frac);
                for (int unsigned j = 0; j < picked_cnt; j++) begin
                    if (picked[j] == unit) begin
                        picked_cnt = 0;
                        if (attempts != 16'hFFFF) attempts++;
                        return;
                    end
                end
                picked[picked_cnt] = unit;
                picked_cnt++;
                if (picked_cnt == k) begin
                    for (int unsigned j = 0; j < k; j++) begin
                        sample_beats.push_back('{picked[j], j[3:0], j + 1 == k, attempts});
                    end
                    picked_cnt = 0;
                    attempts = 16'd1;
                end
            end
            default: ;
        endcase
    endtask

    // Input driver: one beat in flight, random gap before each next beat.
    int unsigned in_gap = 0;
    int unsigned in_mode_left = 0;
    bit in_no_idle = 1'b0;
    t_item cur_item;
    always @(posedge i_clk) begin
        bit busy;
        logic nxt_valid;
        busy = in_ch.valid;
        nxt_valid = in_ch.valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_item(cur_item);
                busy = 1'b0;
                nxt_valid = 1'b0;
                if (in_mode_left == 0) begin
                    in_no_idle = ($urandom_range(0, 3) == 0);
                    in_mode_left = $urandom_range(5, 40);
                end else begin
                    in_mode_left--;
                end
                in_gap = (fast_feed || in_no_idle) ? 0 : $urandom_range(0, 17);
            end
            if (!busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    in_ch.opcode <= cur_item.op;
                    in_ch.entry_index <= cur_item.idx;
                    in_ch.entry_value <= cur_item.val;
                    in_ch.random_fraction <= cur_item.frac;
                    nxt_valid = 1'b1;
                end
            end
        end
        in_ch.valid <= nxt_valid;
    end

    // Output monitor: checks each beat and idles ready at random.
    int unsigned out_stall = 0;
    int unsigned hold_left = 0;
    int unsigned beats_seen = 0;
    int unsigned out_mode_left = 0;
    bit out_no_idle = 1'b0;
    always @(posedge i_clk) begin
        t_member_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                beats_seen++;
                if (sample_beats.size() == 0) begin
                    $error("unexpected beat: member_index %0d", out_ch.member_index);
                    errors++;
                end else begin
                    want = sample_beats.pop_front();
                    if (out_ch.member_index !== want.member) begin
                        $error("member_index expected %0d actual %0d",
                               want.member, out_ch.member_index);
                        errors++;
                    end
                    if (out_ch.position !== want.pos) begin
                        $error("position expected %0d actual %0d", want.pos, out_ch.position);
                        errors++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, out_ch.last);
                        errors++;
                    end
                    if (out_ch.try_count !== want.tries) begin
                        $error("try_count expected %0d actual %0d",
                               want.tries, out_ch.try_count);
                        errors++;
                    end
                end
                if (out_mode_left == 0) begin
                    out_no_idle = ($urandom_range(0, 3) == 0);
                    out_mode_left = $urandom_range(5, 40);
                end else begin
                    out_mode_left--;
                end
                out_stall = out_no_idle ? 0 : $urandom_range(0, 17);
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long back-pressure so the sampler fills up and stalls its input.
    int unsigned holds_done = 0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if ((holds_done == 0 && beats_seen >= 10) ||
                     (holds_done == 1 && beats_seen >= 50)) begin
            hold_left = 600;
            holds_done++;
        end
    end

    // Watchdog.
    int unsigned cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES && !all_done) begin
            $display("FAIL pps_rejection_sampler");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] op, logic [9:0] idx, logic [31:0] val,
                             logic [31:0] frac);
        pending_items.push_back('{op, idx, val, frac});
    endtask

    // Build both cumulative tables over the units in use and queue the loads.
    task automatic load_tables(int unsigned shape);
        logic [32:0] acc_w;
        logic [32:0] acc_r;
        logic [32:0] inc;
        int unsigned p;
        p = units_in_use();
        acc_w = 0;
        acc_r = 0;
        for (int i = 0; i < p; i++) begin
            for (int t = 0; t < 2; t++) begin
                case (shape)
                    0: inc = $urandom_range(0, 8_000_000);
                    1: inc = ($urandom_range(0, 3) == 0) ? {1'b0, $urandom} >> 3 : 33'd0;
                    2: inc = 33'd0;
                    default: inc = $urandom_range(1000, 4_200_000);
                endcase
                if (t == 0) begin
                    acc_w = acc_w + inc;
                    if (acc_w[32]) acc_w = 33'h0FFFFFFFF;
                    plan_w[i] = acc_w[31:0];
                end else begin
                    acc_r = acc_r + inc;
                    if (acc_r[32]) acc_r = 33'h0FFFFFFFF;
                    plan_r[i] = acc_r[31:0];
                end
            end
        end
        // The top entry takes the full scale in most shapes.
        if (shape != 2) begin
            plan_w[p-1] = 32'hFFFFFFFF;
            plan_r[p-1] = 32'hFFFFFFFF;
        end
        for (int i = 0; i < p; i++) begin
            push_item(pps_pkg::OP_LOAD_W, i[9:0], plan_w[i], $urandom);
            push_item(pps_pkg::OP_LOAD_R, i[9:0], plan_r[i], $urandom);
        end
    endtask

    // Rewrite one entry in use with a value that keeps its table nondecreasing.
    task automatic reload_entry();
        int unsigned i;
        int unsigned p;
        logic [31:0] lo;
        logic [31:0] hi;
        bit ratio;
        p = units_in_use();
        i = $urandom_range(0, p - 1);
        ratio = $urandom_range(0, 1);
        lo = (i == 0) ? 32'd0 : (ratio ? plan_r[i-1] : plan_w[i-1]);
        hi = (i == p - 1) ? 32'hFFFFFFFF : (ratio ? plan_r[i+1] : plan_w[i+1]);
        if (ratio) begin
            plan_r[i] = lo + ($urandom % ({32'd0, hi - lo} + 64'd1));
            push_item(pps_pkg::OP_LOAD_R, i[9:0], plan_r[i], $urandom);
        end else begin
            plan_w[i] = lo + ($urandom % ({32'd0, hi - lo} + 64'd1));
            push_item(pps_pkg::OP_LOAD_W, i[9:0], plan_w[i], $urandom);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_ch.valid || sample_beats.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pps_pkg::CFG_IDX_W-1:0] idx,
                             logic [pps_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pps_pkg::CFG_POP) pop_reg = data[pps_pkg::PSZ_W-1:0];
        else samp_reg = data[pps_pkg::SSZ_W-1:0];
        picked_cnt = 0;
        attempts = 16'd1;
    endtask

    // Random part of one setting: mostly draws, some reloads and unused opcodes.
    task automatic random_draws(int unsigned count);
        int unsigned roll;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) push_item(pps_pkg::OP_DRAW, $urandom, $urandom, $urandom);
            else if (roll < 95) reload_entry();
            else push_item(OP_SPARE, $urandom, $urandom, $urandom);
        end
    endtask

    typedef struct {
        int unsigned pop;
        int unsigned samp;
        int unsigned shape;
        int unsigned draws;
    } t_setting;

    t_setting settings_list [8] = '{
        '{1, 1, 2, 12}, '{0, 0, 3, 12}, '{2, 2, 0, 25}, '{8, 3, 3, 30},
        '{16, 16, 3, 30}, '{5, 5, 0, 40}, '{24, 31, 0, 40}, '{12, 4, 1, 30}
    };

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        in_ch.random_fraction = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with one sample member: fraction extremes and an unused opcode.
        write_reg(pps_pkg::CFG_POP, 11'd8);
        fast_feed = 1'b1;
        load_tables(0);
        wait_idle();
        fast_feed = 1'b0;
        push_item(pps_pkg::OP_DRAW, 10'd0, 32'd0, 32'd0);
        push_item(pps_pkg::OP_DRAW, 10'h3FF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_item(pps_pkg::OP_DRAW, 10'd0, 32'd0, 32'h80000000);
        push_item(OP_SPARE, 10'h3FF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_item(pps_pkg::OP_DRAW, 10'd0, 32'd0, 32'h00000001);
        push_item(pps_pkg::OP_LOAD_W, 10'h3FF, 32'hFFFFFFFF, 32'd0);
        push_item(pps_pkg::OP_DRAW, 10'd0, 32'd0, 32'hFFFFFFFE);
        wait_idle();

        // One block per setting, including out-of-range register values.
        foreach (settings_list[s]) begin
            write_reg(pps_pkg::CFG_POP, settings_list[s].pop[pps_pkg::CFG_DATA_W-1:0]);
            write_reg(pps_pkg::CFG_SAMP, settings_list[s].samp[pps_pkg::CFG_DATA_W-1:0]);
            fast_feed = 1'b1;
            load_tables(settings_list[s].shape);
            wait_idle();
            fast_feed = 1'b0;
            push_item(pps_pkg::OP_DRAW, 10'd0, 32'd0, 32'd0);
            push_item(pps_pkg::OP_DRAW, 10'd0, 32'd0, 32'hFFFFFFFF);
            random_draws(settings_list[s].draws);
            // Sender pauses here until every expected member has come back.
            wait_idle();
        end

        all_done = 1'b1;
        if (errors == 0) begin
            $display("PASS pps_rejection_sampler");
        end else begin
            $display("FAIL pps_rejection_sampler");
        end
        $finish;
    end
endmodule
